// File: rtl/svef_pkg.sv
`default_nettype none

package svef_pkg;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 11;
  localparam int LIMIT_W    = 13;
  localparam int GAIN_W     = 16;
  localparam int STATE_W    = 21;
  localparam int TENTHS_W   = 14;
  localparam int DIFF_W     = STATE_W + 1;
  localparam int PROD_W     = GAIN_W + 1 + DIFF_W;
  localparam int WIDE_W     = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // stream widths
  localparam int IN_DATA_W  = 4 * BYTE_W;
  localparam int OUT_DATA_W = ((2 * STATE_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * STATE_W;

  // default parameter values
  localparam int FRAC_BITS_DEF = 8;
  localparam int GAIN_BITS_DEF = 16;

  localparam int STATE_MAX = 2 ** (STATE_W - 1) - 1;
  localparam int STATE_MIN = -(2 ** (STATE_W - 1));

  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [TENTHS_W-1:0] tenths_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic signed [LIMIT_W-1:0]  limit_t;
  typedef logic        [GAIN_W-1:0]   gain_t;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_OFFSET = 3'd0,
    CFG_HUM_OFFSET  = 3'd1,
    CFG_TEMP_MIN    = 3'd2,
    CFG_TEMP_MAX    = 3'd3,
    CFG_HUM_MIN     = 3'd4,
    CFG_HUM_MAX     = 3'd5,
    CFG_TEMP_GAIN   = 3'd6,
    CFG_HUM_GAIN    = 3'd7
  } cfg_idx_e;

  // register reset values
  localparam offset_t TEMP_OFFSET_RST = -11'sd30;
  localparam offset_t HUM_OFFSET_RST  = 11'sd70;
  localparam limit_t  TEMP_MIN_RST    = 13'sd0;
  localparam limit_t  TEMP_MAX_RST    = 13'sd500;
  localparam limit_t  HUM_MIN_RST     = 13'sd200;
  localparam limit_t  HUM_MAX_RST     = 13'sd900;
  localparam gain_t   TEMP_GAIN_RST   = 16'd5243;
  localparam gain_t   HUM_GAIN_RST    = 16'd5243;

  // calibrated reading of one channel
  typedef struct packed {
    tenths_t value;
    logic    in_range;
  } cal_t;

  // clamp a wide signed value into the state range
  function automatic state_t sat_state(input logic signed [WIDE_W-1:0] v);
    state_t r;
    if (v > WIDE_W'(STATE_MAX)) begin
      r = state_t'(STATE_MAX);
    end else if (v < WIDE_W'(STATE_MIN)) begin
      r = state_t'(STATE_MIN);
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/svef_cal.sv
`default_nettype none

module svef_cal (
  input  logic                          [svef_pkg::BYTE_W-1:0] whole_i,
  input  logic                          [svef_pkg::BYTE_W-1:0] tenths_i,
  input  svef_pkg::offset_t                                    offset_i,
  input  svef_pkg::limit_t                                     min_i,
  input  svef_pkg::limit_t                                     max_i,
  output svef_pkg::cal_t                                       cal_o
);
  import svef_pkg::*;

  tenths_t value;

  // whole * 10 + tenths + offset, all in tenths
  assign value = $signed(TENTHS_W'(whole_i) * TENTHS_W'(10) + TENTHS_W'(tenths_i)
                         + TENTHS_W'(offset_i));

  // inclusive window check
  assign cal_o.value    = value;
  assign cal_o.in_range = (value >= TENTHS_W'(min_i)) && (value <= TENTHS_W'(max_i));

endmodule

`default_nettype wire

// File: rtl/svef_ema.sv
`default_nettype none

module svef_ema #(
  parameter int FRAC_BITS = svef_pkg::FRAC_BITS_DEF,
  parameter int GAIN_BITS = svef_pkg::GAIN_BITS_DEF
) (
  input  svef_pkg::state_t  state_i,
  input  svef_pkg::tenths_t meas_i,
  input  svef_pkg::gain_t   gain_i,
  input  logic              primed_i,
  output svef_pkg::state_t  state_o
);
  import svef_pkg::*;

  logic signed [WIDE_W-1:0] scl_wide;
  state_t                   scl;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] step;
  logic signed [WIDE_W-1:0] sum_wide;

  // measurement scaled to the state format, clamped
  assign scl_wide = WIDE_W'(meas_i) <<< FRAC_BITS;
  assign scl      = sat_state(scl_wide);

  // gain * (meas - state), floor by arithmetic shift
  assign diff = DIFF_W'(scl) - DIFF_W'(state_i);
  assign prod = PROD_W'($signed({1'b0, gain_i})) * PROD_W'(diff);
  assign step = prod >>> GAIN_BITS;

  assign sum_wide = WIDE_W'(state_i) + WIDE_W'(step);

  // first accepted reading loads directly
  assign state_o = primed_i ? sat_state(sum_wide) : scl;

endmodule

`default_nettype wire

// File: rtl/sensor_validated_ema_filter_top.sv
`default_nettype none

// Validated exponential moving average for a temperature / humidity sensor.
// Each input item carries one raw reading; each one yields exactly one result
// item with the filtered state after that reading. An item is held in the
// input register, then a single combinational pass (calibration, window
// check and one 17x22 multiply per channel) writes the state and the output
// register, so the block takes one item per cycle while the output is not
// stalled; the recurrence closes within that one pass. s_axis_tready drops
// only while both the input and output registers are full and the output is
// stalled. Configuration writes are always taken (cfg_ready_o is tied high).
module sensor_validated_ema_filter_top #(
  parameter int FRAC_BITS = svef_pkg::FRAC_BITS_DEF,
  parameter int GAIN_BITS = svef_pkg::GAIN_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: hum_whole, hum_tenths, temp_whole, temp_tenths (8 bits each)
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [svef_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // tuser: read_ok
  input  logic                                  s_axis_tuser,
  // tdata: smoothed_temp [20:0], smoothed_hum [41:21], zero fill
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [svef_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // tuser: have_value, sample_taken
  output logic [1:0]                            m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [svef_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [svef_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import svef_pkg::*;

  // configuration registers
  offset_t temp_offset_q, hum_offset_q;
  limit_t  temp_min_q, temp_max_q, hum_min_q, hum_max_q;
  gain_t   temp_gain_q, hum_gain_q;

  // input register
  logic                   in_vld_q;
  logic                   read_ok_q;
  logic [IN_DATA_W-1:0]   in_data_q;

  // filter state
  state_t temp_q, hum_q, temp_d, hum_d;
  logic   primed_q;

  // output register
  logic   out_vld_q;
  state_t out_temp_q, out_hum_q;
  logic   out_have_q, out_taken_q;

  logic   out_free, advance, take;
  cal_t   temp_cal, hum_cal;

  assign cfg_ready_o = 1'b1;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_offset_q <= TEMP_OFFSET_RST;
      hum_offset_q  <= HUM_OFFSET_RST;
      temp_min_q    <= TEMP_MIN_RST;
      temp_max_q    <= TEMP_MAX_RST;
      hum_min_q     <= HUM_MIN_RST;
      hum_max_q     <= HUM_MAX_RST;
      temp_gain_q   <= TEMP_GAIN_RST;
      hum_gain_q    <= HUM_GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TEMP_OFFSET: temp_offset_q <= cfg_data_i[OFFSET_W-1:0];
        CFG_HUM_OFFSET:  hum_offset_q  <= cfg_data_i[OFFSET_W-1:0];
        CFG_TEMP_MIN:    temp_min_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_TEMP_MAX:    temp_max_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_HUM_MIN:     hum_min_q     <= cfg_data_i[LIMIT_W-1:0];
        CFG_HUM_MAX:     hum_max_q     <= cfg_data_i[LIMIT_W-1:0];
        CFG_TEMP_GAIN:   temp_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_HUM_GAIN:    hum_gain_q    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      read_ok_q <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
  end

  // calibration and window check
  svef_cal u_hum_cal (
    .whole_i  (in_data_q[BYTE_W-1:0]),
    .tenths_i (in_data_q[2*BYTE_W-1:BYTE_W]),
    .offset_i (hum_offset_q),
    .min_i    (hum_min_q),
    .max_i    (hum_max_q),
    .cal_o    (hum_cal)
  );

  svef_cal u_temp_cal (
    .whole_i  (in_data_q[3*BYTE_W-1:2*BYTE_W]),
    .tenths_i (in_data_q[4*BYTE_W-1:3*BYTE_W]),
    .offset_i (temp_offset_q),
    .min_i    (temp_min_q),
    .max_i    (temp_max_q),
    .cal_o    (temp_cal)
  );

  assign take = read_ok_q && temp_cal.in_range && hum_cal.in_range;

  // smoothing update per channel
  svef_ema #(
    .FRAC_BITS (FRAC_BITS),
    .GAIN_BITS (GAIN_BITS)
  ) u_temp_ema (
    .state_i  (temp_q),
    .meas_i   (temp_cal.value),
    .gain_i   (temp_gain_q),
    .primed_i (primed_q),
    .state_o  (temp_d)
  );

  svef_ema #(
    .FRAC_BITS (FRAC_BITS),
    .GAIN_BITS (GAIN_BITS)
  ) u_hum_ema (
    .state_i  (hum_q),
    .meas_i   (hum_cal.value),
    .gain_i   (hum_gain_q),
    .primed_i (primed_q),
    .state_o  (hum_d)
  );

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q   <= '0;
      hum_q    <= '0;
      primed_q <= 1'b0;
    end else if (advance && take) begin
      temp_q   <= temp_d;
      hum_q    <= hum_d;
      primed_q <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_temp_q  <= take ? temp_d : temp_q;
      out_hum_q   <= take ? hum_d : hum_q;
      out_have_q  <= take || primed_q;
      out_taken_q <= take;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_hum_q, out_temp_q};
  assign m_axis_tuser  = {out_taken_q, out_have_q};

  // state stays zero until the first accepted reading
  a_unprimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !primed_q |-> (temp_q == '0) && (hum_q == '0))
    else $error("state nonzero before first accepted reading");

  // an accepted reading primes the filter
  a_take_primes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && take |=> primed_q)
    else $error("accepted reading did not prime the filter");

  // every advance lands in the output register with its flag
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q && (out_taken_q == $past(take)))
    else $error("item lost between input and output register");

  // taken implies have_value on the same result
  a_taken_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_taken_q |-> out_have_q)
    else $error("sample taken without have_value");

  // input only stalls when both stages are full and the output waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
